/* src/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the asynchronous reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/lkm_pkg.sv */
package lkm_pkg;

	// Register map of the write port
	typedef enum logic [1:0] {
		CFG_CASE_FOLD    = 2'd0,
		CFG_NUMBER_LINES = 2'd1,
		CFG_KEY_LENGTH   = 2'd2,
		CFG_KEYWORD      = 2'd3
	} cfg_index_t;

	localparam int CFG_DATA_W  = 64;
	localparam int KEYLEN_W    = 4;
	localparam int KEY_LANES   = 8;
	localparam int LINE_NUM_W  = 24;
	localparam int PIECE_LEN_W = 7;
	localparam int OUT_DATA_W  = 32;

	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_NUL     = 8'h00;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	// Map a-z to A-Z, leave everything else alone
	function automatic logic [7:0] fold_byte(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
			r = b - CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

/* src/line_keyword_matcher_core.sv */
// Fixed-string line matcher. Text enters one byte per transaction on the s_axis side and is
// cut into pieces: a piece closes on a newline byte, on reaching LINE_BUFFER-1 bytes, or on a
// byte marked with tlast. Every closed piece takes the next line number (saturating at
// 2^COUNT_WIDTH-1); a piece whose bytes before its first zero byte contain the keyword yields
// one m_axis transaction with its line number, its length and the number_lines flag.
// Throughput is one byte per cycle: the input register feeds a single compare stage that
// checks the sliding keyword window against every keyword length at once, and the result
// lands in an output register once the byte has left the input register. Input only stalls when
// a matching piece closes while the previous result is still waiting on m_axis_tready.
// Configuration (case_fold, number_lines, key_length, keyword_bytes at indexes 0..3) is
// written through cfg_we/cfg_index/cfg_data and must only change while the block is idle.
module line_keyword_matcher_core
	import lkm_pkg::*;
#(
	parameter int KEY_MAX     = 8,
	parameter int LINE_BUFFER = 100,
	parameter int COUNT_WIDTH = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// text stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // [7:0] text_byte
	input  logic                  s_axis_tlast,  // final_req
	// match results
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [23:0] line_number, [30:24] piece_length
	output logic                  m_axis_tuser,  // numbered
	// configuration writes
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int WIN_W = 8 * KEY_MAX;
	localparam int PW    = $clog2(LINE_BUFFER);
	localparam int CMPW  = ((PW > KEYLEN_W) ? PW : KEYLEN_W) + 1;
	localparam logic [PW:0] PIECE_LIMIT = (PW + 1)'(LINE_BUFFER - 1);

	// configuration registers
	logic                  case_fold_q;
	logic                  number_lines_q;
	logic [KEYLEN_W-1:0]   key_length_q;
	logic [CFG_DATA_W-1:0] keyword_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// per-piece state
	logic [WIN_W-1:0]       window_q;
	logic [PW-1:0]          piece_count_q;
	logic                   hit_q;
	logic                   zero_seen_q;
	logic [COUNT_WIDTH-1:0] line_count_q;

	// output register
	logic                   out_valid_q;
	logic [LINE_NUM_W-1:0]  out_line_q;
	logic [PIECE_LEN_W-1:0] out_len_q;
	logic                   out_numbered_q;

	// compare stage
	logic [KEYLEN_W-1:0]    klen_clip;
	logic [KEYLEN_W-1:0]    key_len;
	logic [WIN_W-1:0]       win_next;
	logic [7:0]             key_cmp [KEY_MAX];
	logic [7:0]             win_cmp [KEY_MAX];
	logic [KEY_MAX:0]       len_match;
	logic                   key_match;
	logic [PW:0]            cnt_next;
	logic                   count_ok;
	logic                   is_nul;
	logic                   hit_next;
	logic                   piece_end;
	logic                   produce;
	logic                   out_free;
	logic                   s1_advance;
	logic                   in_accept;
	logic [COUNT_WIDTH-1:0] line_next;
	logic [31:0]            line_ext;
	logic [15:0]            len_ext;

	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s1_advance    = valid_s1 && (!produce || out_free);
	assign s_axis_tready = !valid_s1 || s1_advance;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_len_q, out_line_q};
	assign m_axis_tuser  = out_numbered_q;

	// Configuration writes land directly; no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_fold_q    <= 1'b0;
			number_lines_q <= 1'b0;
			key_length_q   <= '0;
			keyword_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CASE_FOLD:    case_fold_q    <= cfg_data[0];
				CFG_NUMBER_LINES: number_lines_q <= cfg_data[0];
				CFG_KEY_LENGTH:   key_length_q   <= cfg_data[KEYLEN_W-1:0];
				CFG_KEYWORD:      keyword_q      <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_comb begin
		// Effective keyword length: clip to KEY_MAX, then stop at the first NUL byte.
		klen_clip = (key_length_q > KEYLEN_W'(KEY_MAX)) ? KEYLEN_W'(KEY_MAX) : key_length_q;
		key_len   = klen_clip;
		for (int i = KEY_LANES - 1; i >= 0; i--) begin
			if (KEYLEN_W'(i) < klen_clip && keyword_q[8*i +: 8] == CHAR_NUL) begin
				key_len = KEYLEN_W'(i);
			end
		end

		// Shift the new byte into the top lane.
		win_next = (window_q >> 8) | (WIN_W'(byte_s1) << (WIN_W - 8));

		for (int i = 0; i < KEY_MAX; i++) begin
			key_cmp[i] = case_fold_q ? fold_byte(keyword_q[8*i +: 8]) : keyword_q[8*i +: 8];
			win_cmp[i] = case_fold_q ? fold_byte(win_next[8*i +: 8]) : win_next[8*i +: 8];
		end

		// For each candidate length, compare the keyword against the newest lanes.
		for (int kk = 0; kk <= KEY_MAX; kk++) begin
			len_match[kk] = 1'b1;
			for (int i = 0; i < kk; i++) begin
				if (key_cmp[i] != win_cmp[KEY_MAX - kk + i]) begin
					len_match[kk] = 1'b0;
				end
			end
		end

		key_match = 1'b0;
		for (int kk = 0; kk <= KEY_MAX; kk++) begin
			if (key_len == KEYLEN_W'(kk)) begin
				key_match = len_match[kk];
			end
		end

		cnt_next  = {1'b0, piece_count_q} + 1'b1;
		count_ok  = CMPW'(cnt_next) >= CMPW'(key_len);
		is_nul    = (byte_s1 == CHAR_NUL);
		hit_next  = hit_q || (key_len == '0)
			|| (!zero_seen_q && !is_nul && count_ok && key_match);
		piece_end = (byte_s1 == CHAR_NEWLINE) || last_s1 || (cnt_next >= PIECE_LIMIT);
		produce   = piece_end && hit_next;

		// Saturating line counter
		line_next = (line_count_q != '1) ? line_count_q + 1'b1 : line_count_q;
		line_ext  = 32'(line_next);
		len_ext   = 16'(cnt_next);
	end

	// Input register: hold the byte while the compare stage is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Piece state: advance per compare-stage byte (window stops at NUL), clear at piece end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q      <= '0;
			piece_count_q <= '0;
			hit_q         <= 1'b0;
			zero_seen_q   <= 1'b0;
			line_count_q  <= '0;
		end else if (s1_advance) begin
			if (piece_end) begin
				window_q      <= '0;
				piece_count_q <= '0;
				hit_q         <= 1'b0;
				zero_seen_q   <= 1'b0;
				line_count_q  <= line_next;
			end else begin
				if (!zero_seen_q && !is_nul) begin
					window_q <= win_next;
				end
				piece_count_q <= cnt_next[PW-1:0];
				hit_q         <= hit_next;
				zero_seen_q   <= zero_seen_q || is_nul;
			end
		end
	end

	// Output register: load a result, drop it once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_advance && produce) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance && produce) begin
			out_line_q     <= line_ext[LINE_NUM_W-1:0];
			out_len_q      <= len_ext[PIECE_LEN_W-1:0];
			out_numbered_q <= number_lines_q;
		end
	end

endmodule

/* src/lkm_checker.sv */
`include "assert_macros.svh"

module lkm_checker
	import lkm_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	// A result that is not taken holds its value.
	`ASSERT_CLK(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	// Input only stalls behind a result that is still waiting.
	`ASSERT_CLK(a_stall_cause, clk, arst_n, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

	// A fresh result comes from a byte taken on the input and passed through the input register.
	`ASSERT_CLK(a_result_src, clk, arst_n, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2), "result without a matching input transaction")

endmodule

bind line_keyword_matcher_core lkm_checker u_lkm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
